>>> hw/rtl/ssl_pkg.sv
`default_nettype none

package ssl_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W    = 20;
  localparam int ADDR_W   = 4;

  localparam logic [7:0]  MOVE_TIMEOUT = 8'hFF;
  localparam logic [7:0]  HOLD_TICKS   = 8'd4;
  localparam logic [15:0] PWM_OFFSET   = 16'd2000;

  // (p + 2000) * 64 / 100 equals (16 * (p + 2000)) / 25; the quotient by 25 is taken
  // as a multiplication by ceil(2^26 / 25) followed by a shift, exact below 2^21.
  localparam int          RECIP_SHIFT = 26;
  localparam logic [21:0] RECIP_25    = 22'd2684355;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_SET  = 2'd1;
  localparam logic [1:0] FUNC_DOOR = 2'd2;

  localparam logic [1:0] KIND_PWM   = 2'd0;
  localparam logic [1:0] KIND_POWER = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  localparam logic [1:0] REG_POS_MIN   = 2'd0;
  localparam logic [1:0] REG_POS_MAX   = 2'd1;
  localparam logic [1:0] REG_DEF_SPEED = 2'd2;
  localparam logic [1:0] REG_DOOR_DIR  = 2'd3;

  typedef struct packed {
    logic [15:0] pos_min;
    logic [15:0] pos_max;
    logic [15:0] default_speed;
    logic        door_direction;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  channel;
    logic [15:0] value;
    logic        ack_is_door;
    logic [7:0]  ack_to;
    logic        last;
  } res_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CMD   = 7'b0000010,
    S_CALC  = 7'b0000100,
    S_ACK   = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_PWM   = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/servo_slew_limiter_bank.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    func, channel, value, speed, requester, broadcast flag
// out       out_valid / out_ready  kind, channel, value, ack_is_door, ack_to, last
// cfg       psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// A command transaction passes through the accept, command and flush states; a tick
// transaction through accept, one evaluation per channel, a multiply and a PWM step per
// moving channel, an acknowledge per acknowledged timeout, and a flush that moves the last result out.
// Channels are evaluated one at a time by a single shared step unit and one multiplier.
// Reset is synchronous and active low; all channel state clears at once.
// A stalled output holds the sequencer; in_ready is high only while idle.
`default_nettype none

module servo_slew_limiter_bank (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_func,
  input  wire logic [3:0]                 in_channel,
  input  wire logic [15:0]                in_value,
  input  wire logic [15:0]                in_speed,
  input  wire logic [7:0]                 in_requester,
  input  wire logic                       in_requester_is_broadcast,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [1:0]                 out_kind,
  output logic      [3:0]                 out_channel,
  output logic      [15:0]                out_value,
  output logic                            out_ack_is_door,
  output logic      [7:0]                 out_ack_to,
  output logic                            out_last,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import ssl_pkg::*;

  cfg_t cfg;

  state_t state_r, state_nxt;
  logic [CH_W-1:0] idx_r, idx_nxt;

  logic [1:0]      cmd_func_r, cmd_func_nxt;
  logic [CH_W-1:0] cmd_ch_r, cmd_ch_nxt;
  logic [15:0]     cmd_value_r, cmd_value_nxt;
  logic [15:0]     cmd_speed_r, cmd_speed_nxt;
  logic [7:0]      cmd_req_r, cmd_req_nxt;
  logic            cmd_bcast_r, cmd_bcast_nxt;

  logic [POS_W-1:0] pos_r [CHANNELS];
  logic [POS_W-1:0] pos_nxt [CHANNELS];
  logic [15:0]      tgt_r [CHANNELS];
  logic [15:0]      tgt_nxt [CHANNELS];
  logic [15:0]      step_r [CHANNELS];
  logic [15:0]      step_nxt [CHANNELS];
  logic [7:0]       cd_r [CHANNELS];
  logic [7:0]       cd_nxt [CHANNELS];
  logic [7:0]       ackaddr_r [CHANNELS];
  logic [7:0]       ackaddr_nxt [CHANNELS];
  logic             ackw_r [CHANNELS];
  logic             ackw_nxt [CHANNELS];
  logic             door_r [CHANNELS];
  logic             door_nxt [CHANNELS];

  res_t pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt;
  res_t out_res_r, out_res_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [POS_W-1:0] step_pos;
  logic             step_moved;
  logic [15:0]      pwm_compare;

  logic        out_free;
  logic        can_emit;
  logic        emit_en;
  res_t        emit_res;
  logic        adv;
  logic        door_open;
  logic [15:0] raw_tgt;
  logic [15:0] clamp_tgt;
  logic [15:0] door_lim;
  logic [3:0]  idx_ch;

  ssl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssl_step u_step (
    .pos     (pos_r[idx_r]),
    .goal    (tgt_r[idx_r]),
    .step    (step_r[idx_r]),
    .new_pos (step_pos),
    .moved   (step_moved)
  );

  ssl_pwm u_pwm (
    .clk     (clk),
    .pos     (pos_r[idx_r][15:0]),
    .compare (pwm_compare)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_kind        = out_res_r.kind;
  assign out_channel     = out_res_r.channel;
  assign out_value       = out_res_r.value;
  assign out_ack_is_door = out_res_r.ack_is_door;
  assign out_ack_to      = out_res_r.ack_to;
  assign out_last        = out_res_r.last;

  assign out_free  = !out_valid_r || out_ready;
  assign can_emit  = !pend_v_r || out_free;
  assign door_open = (cmd_value_r != 16'd0);
  assign door_lim  = cfg.door_direction ? cfg.pos_max : cfg.pos_min;
  assign idx_ch    = 4'(idx_r);

  always_comb begin
    if (cmd_func_r == FUNC_DOOR) begin
      raw_tgt = (door_open == cfg.door_direction) ? cfg.pos_max : cfg.pos_min;
    end else begin
      raw_tgt = cmd_value_r;
    end
    if (raw_tgt > cfg.pos_max) begin
      clamp_tgt = cfg.pos_max;
    end else if (raw_tgt < cfg.pos_min) begin
      clamp_tgt = cfg.pos_min;
    end else begin
      clamp_tgt = raw_tgt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd_func_nxt  = cmd_func_r;
    cmd_ch_nxt    = cmd_ch_r;
    cmd_value_nxt = cmd_value_r;
    cmd_speed_nxt = cmd_speed_r;
    cmd_req_nxt   = cmd_req_r;
    cmd_bcast_nxt = cmd_bcast_r;
    pos_nxt       = pos_r;
    tgt_nxt       = tgt_r;
    step_nxt      = step_r;
    cd_nxt        = cd_r;
    ackaddr_nxt   = ackaddr_r;
    ackw_nxt      = ackw_r;
    door_nxt      = door_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    emit_en       = 1'b0;
    emit_res      = '0;
    emit_res.channel = idx_ch;
    adv           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_func_nxt  = in_func;
          cmd_ch_nxt    = in_channel[CH_W-1:0];
          cmd_value_nxt = in_value;
          cmd_speed_nxt = in_speed;
          cmd_req_nxt   = in_requester;
          cmd_bcast_nxt = in_requester_is_broadcast;
          if (in_func == FUNC_TICK) begin
            idx_nxt   = '0;
            state_nxt = S_CALC;
          end else if ((in_func == FUNC_SET || in_func == FUNC_DOOR) &&
                       ({1'b0, in_channel} < 5'(CHANNELS))) begin
            state_nxt = S_CMD;
          end
        end
      end
      S_CMD: begin
        if (can_emit) begin
          tgt_nxt[cmd_ch_r]     = clamp_tgt;
          cd_nxt[cmd_ch_r]      = MOVE_TIMEOUT;
          step_nxt[cmd_ch_r]    = (cmd_func_r == FUNC_SET && cmd_speed_r != 16'd0) ?
                                  cmd_speed_r : cfg.default_speed;
          ackw_nxt[cmd_ch_r]    = !cmd_bcast_r;
          ackaddr_nxt[cmd_ch_r] = cmd_bcast_r ? 8'd0 : cmd_req_r;
          door_nxt[cmd_ch_r]    = (cmd_func_r == FUNC_DOOR);
          emit_en               = 1'b1;
          emit_res.kind         = KIND_POWER;
          emit_res.channel      = 4'(cmd_ch_r);
          emit_res.value        = 16'd1;
          state_nxt             = S_FLUSH;
        end
      end
      S_CALC: begin
        if (cd_r[idx_r] == 8'd0) begin
          adv = 1'b1;
        end else if (cd_r[idx_r] == 8'd1) begin
          if (can_emit) begin
            cd_nxt[idx_r]  = 8'd0;
            emit_en        = 1'b1;
            emit_res.kind  = KIND_POWER;
            emit_res.value = 16'd0;
            if (ackw_r[idx_r]) begin
              state_nxt = S_ACK;
            end else begin
              adv = 1'b1;
            end
          end
        end else if (step_moved) begin
          pos_nxt[idx_r] = step_pos;
          cd_nxt[idx_r]  = HOLD_TICKS;
          state_nxt      = S_MUL;
        end else begin
          cd_nxt[idx_r] = cd_r[idx_r] - 8'd1;
          adv           = 1'b1;
        end
      end
      S_ACK: begin
        if (can_emit) begin
          emit_en              = 1'b1;
          emit_res.kind        = KIND_ACK;
          emit_res.ack_is_door = door_r[idx_r];
          emit_res.ack_to      = ackaddr_r[idx_r];
          if (door_r[idx_r]) begin
            emit_res.value = (pos_r[idx_r] == {{(POS_W-16){1'b0}}, door_lim}) ?
                             16'd1 : 16'd0;
          end else begin
            emit_res.value = pos_r[idx_r][15:0];
          end
          adv = 1'b1;
        end
      end
      S_MUL: begin
        state_nxt = S_PWM;
      end
      S_PWM: begin
        if (can_emit) begin
          emit_en        = 1'b1;
          emit_res.kind  = KIND_PWM;
          emit_res.value = pwm_compare;
          adv            = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_res_nxt      = pend_r;
          out_res_nxt.last = 1'b1;
          out_valid_nxt    = 1'b1;
          pend_v_nxt       = 1'b0;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit_en) begin
      if (pend_v_r) begin
        out_res_nxt      = pend_r;
        out_res_nxt.last = 1'b0;
        out_valid_nxt    = 1'b1;
      end
      pend_nxt   = emit_res;
      pend_v_nxt = 1'b1;
    end

    if (adv) begin
      if (idx_r == CH_W'(CHANNELS - 1)) begin
        state_nxt = S_FLUSH;
      end else begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_CALC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pos_r[i]     <= '0;
        tgt_r[i]     <= '0;
        step_r[i]    <= '0;
        cd_r[i]      <= '0;
        ackaddr_r[i] <= '0;
        ackw_r[i]    <= 1'b0;
        door_r[i]    <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      tgt_r       <= tgt_nxt;
      step_r      <= step_nxt;
      cd_r        <= cd_nxt;
      ackaddr_r   <= ackaddr_nxt;
      ackw_r      <= ackw_nxt;
      door_r      <= door_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_func_r  <= cmd_func_nxt;
    cmd_ch_r    <= cmd_ch_nxt;
    cmd_value_r <= cmd_value_nxt;
    cmd_speed_r <= cmd_speed_nxt;
    cmd_req_r   <= cmd_req_nxt;
    cmd_bcast_r <= cmd_bcast_nxt;
    pend_r      <= pend_nxt;
    out_res_r   <= out_res_nxt;
  end

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_v_r)
    else $error("pending result held while idle");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == FUNC_TICK) |=> !in_ready)
    else $error("tick transaction did not occupy the sequencer");

  a_pwm_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PWM) |-> (cd_r[idx_r] == HOLD_TICKS))
    else $error("moving channel lost its hold count");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/ssl_regs.sv
`default_nettype none

module ssl_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ssl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output ssl_pkg::cfg_t                  cfg
);
  import ssl_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_POS_MIN:   cfg_nxt.pos_min        = pwdata[15:0];
        REG_POS_MAX:   cfg_nxt.pos_max        = pwdata[15:0];
        REG_DEF_SPEED: cfg_nxt.default_speed  = pwdata[15:0];
        REG_DOOR_DIR:  cfg_nxt.door_direction = pwdata[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POS_MIN:   prdata = {16'd0, cfg_r.pos_min};
      REG_POS_MAX:   prdata = {16'd0, cfg_r.pos_max};
      REG_DEF_SPEED: prdata = {16'd0, cfg_r.default_speed};
      REG_DOOR_DIR:  prdata = {31'd0, cfg_r.door_direction};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_min        <= 16'd0;
      cfg_r.pos_max        <= 16'd10000;
      cfg_r.default_speed  <= 16'd100;
      cfg_r.door_direction <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ssl_step.sv
`default_nettype none

module ssl_step (
  input  wire logic [ssl_pkg::POS_W-1:0] pos,
  input  wire logic [15:0]               goal,
  input  wire logic [15:0]               step,
  output logic      [ssl_pkg::POS_W-1:0] new_pos,
  output logic                           moved
);
  import ssl_pkg::*;

  logic [POS_W:0]   diff;
  logic [POS_W-1:0] goal_w;
  logic [POS_W-1:0] mag;
  logic             up;
  logic             reach;

  assign goal_w = {{(POS_W-16){1'b0}}, goal};
  assign diff   = {1'b0, goal_w} - {1'b0, pos};
  assign up     = !diff[POS_W];
  assign mag    = up ? diff[POS_W-1:0] : (POS_W)'(-diff);
  assign moved  = (diff != '0);
  assign reach  = mag <= {{(POS_W-16){1'b0}}, step};

  always_comb begin
    if (reach) begin
      new_pos = goal_w;
    end else if (up) begin
      new_pos = pos + {{(POS_W-16){1'b0}}, step};
    end else begin
      new_pos = pos - {{(POS_W-16){1'b0}}, step};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ssl_pwm.sv
`default_nettype none

module ssl_pwm (
  input  wire logic        clk,
  input  wire logic [15:0] pos,
  output logic      [15:0] compare
);
  import ssl_pkg::*;

  logic [20:0] scaled;
  logic [42:0] prod;
  logic [15:0] compare_r;

  assign scaled  = {1'b0, ({4'd0, pos} + {4'd0, PWM_OFFSET})} << 4;
  assign prod    = {22'd0, scaled} * {21'd0, RECIP_25};
  assign compare = compare_r;

  always_ff @(posedge clk) begin
    compare_r <= prod[RECIP_SHIFT+15:RECIP_SHIFT];
  end

endmodule

`default_nettype wire

>>> verif/servo_slew_limiter_bank_test.sv
module servo_slew_limiter_bank_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssl_pkg::*;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PWM_MUL         = 64;
  localparam int PWM_DIV         = 100;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  class servo_bank_predictor;
    logic [15:0] pos_min;
    logic [15:0] pos_max;
    logic [15:0] default_speed;
    logic        door_direction;
    int unsigned position [CHANNELS];
    logic [15:0] target_pos [CHANNELS];
    logic [15:0] step_size [CHANNELS];
    logic [7:0]  countdown [CHANNELS];
    logic [7:0]  ack_address [CHANNELS];
    logic        ack_wanted [CHANNELS];
    logic        door_mode [CHANNELS];
    res_t        results_due [$];
    int          mismatches;

    function new();
      pos_min = 16'd0;
      pos_max = 16'd10000;
      default_speed = 16'd100;
      door_direction = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        position[i] = 0;
        target_pos[i] = 16'd0;
        step_size[i] = 16'd0;
        countdown[i] = 8'd0;
        ack_address[i] = 8'd0;
        ack_wanted[i] = 1'b0;
        door_mode[i] = 1'b0;
      end
      mismatches = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_POS_MIN:   pos_min = val;
        REG_POS_MAX:   pos_max = val;
        REG_DEF_SPEED: default_speed = val;
        REG_DOOR_DIR:  door_direction = val[0];
        default: ;
      endcase
    endfunction

    function void start_motion(int ch, logic [15:0] goal, logic [15:0] spd,
                               logic [7:0] req, logic bcast);
      if (goal > pos_max) goal = pos_max;
      else if (goal < pos_min) goal = pos_min;
      target_pos[ch] = goal;
      countdown[ch] = MOVE_TIMEOUT;
      step_size[ch] = (spd != 16'd0) ? spd : default_speed;
      ack_wanted[ch] = !bcast;
      ack_address[ch] = bcast ? 8'h00 : req;
    endfunction

    function res_t make_result(logic [1:0] kind, int ch, logic [15:0] val,
                               logic is_door, logic [7:0] to);
      res_t r;
      r.kind = kind;
      r.channel = 4'(ch);
      r.value = val;
      r.ack_is_door = is_door;
      r.ack_to = to;
      r.last = 1'b0;
      return r;
    endfunction

    function void apply_command(logic [1:0] func, logic [3:0] ch, logic [15:0] value,
                                logic [15:0] speed, logic [7:0] req, logic bcast);
      res_t        batch [$];
      res_t        r;
      int unsigned goal;
      int unsigned pos;
      int unsigned step;
      logic [15:0] door_goal;
      logic [15:0] lim;
      logic [15:0] ack_val;
      if (func == FUNC_SET || func == FUNC_DOOR) begin
        if (int'(ch) >= CHANNELS) return;
        if (func == FUNC_SET) begin
          start_motion(ch, value, speed, req, bcast);
          door_mode[ch] = 1'b0;
        end else begin
          if (door_direction) door_goal = (value != 16'd0) ? pos_max : pos_min;
          else door_goal = (value != 16'd0) ? pos_min : pos_max;
          start_motion(ch, door_goal, 16'd0, req, bcast);
          door_mode[ch] = 1'b1;
        end
        batch.push_back(make_result(KIND_POWER, ch, 16'd1, 1'b0, 8'h00));
      end else if (func == FUNC_TICK) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (countdown[i] == 8'd0) continue;
          countdown[i] = countdown[i] - 8'd1;
          if (countdown[i] == 8'd0) begin
            batch.push_back(make_result(KIND_POWER, i, 16'd0, 1'b0, 8'h00));
            if (ack_wanted[i]) begin
              if (door_mode[i]) begin
                lim = door_direction ? pos_max : pos_min;
                ack_val = (position[i] == lim) ? 16'd1 : 16'd0;
              end else begin
                ack_val = 16'(position[i]);
              end
              batch.push_back(make_result(KIND_ACK, i, ack_val, door_mode[i],
                                          ack_address[i]));
            end
            continue;
          end
          goal = target_pos[i];
          pos = position[i];
          step = step_size[i];
          if (goal == pos) continue;
          if (goal > pos) pos = (goal - pos <= step) ? goal : pos + step;
          else pos = (pos - goal <= step) ? goal : pos - step;
          position[i] = pos & 32'h000F_FFFF;
          batch.push_back(make_result(KIND_PWM, i,
            16'(((position[i] + PWM_OFFSET) * PWM_MUL) / PWM_DIV), 1'b0, 8'h00));
          countdown[i] = HOLD_TICKS;
        end
      end
      if (batch.size() > 0) begin
        r = batch.pop_back();
        r.last = 1'b1;
        batch.push_back(r);
        foreach (batch[k]) results_due.push_back(batch[k]);
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (results_due.size() == 0) begin
        $display("%0t: expected no result, got kind %0d channel %0d value %0d",
                 $time, got.kind, got.channel, got.value);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("channel", want.channel, got.channel);
      compare_field("value", want.value, got.value);
      compare_field("ack_is_door", want.ack_is_door, got.ack_is_door);
      compare_field("ack_to", want.ack_to, got.ack_to);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_func = FUNC_TICK;
  logic [3:0]        in_channel = 4'd0;
  logic [15:0]       in_value = 16'd0;
  logic [15:0]       in_speed = 16'd0;
  logic [7:0]        in_requester = 8'd0;
  logic              in_requester_is_broadcast = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_kind;
  logic [3:0]        out_channel;
  logic [15:0]       out_value;
  logic              out_ack_is_door;
  logic [7:0]        out_ack_to;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = 32'd0;
  logic [31:0]       prdata;
  logic              pready;

  servo_bank_predictor board = new();
  int unsigned cycle_count = 0;
  bit idling_on = 1'b1;
  bit hold_request = 1'b0;

  servo_slew_limiter_bank u_top (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        board.check_result({out_kind, out_channel, out_value, out_ack_is_door,
                            out_ack_to, out_last});
      if (in_valid && in_ready)
        board.apply_command(in_func, in_channel, in_value, in_speed, in_requester,
                            in_requester_is_broadcast);
    end
  end

  // The receiver stalls at random while idling_on is set, and once holds off long enough to back up the input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= !(idling_on && $urandom_range(99) < 8);
      end
    end
  end

  task automatic issue_command(input logic [1:0] func, input logic [3:0] ch,
                               input logic [15:0] value, input logic [15:0] speed,
                               input logic [7:0] req, input logic bcast);
    if (idling_on && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 60);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_channel <= ch;
    in_value <= value;
    in_speed <= speed;
    in_requester <= req;
    in_requester_is_broadcast <= bcast;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic tick_random();
    issue_command(FUNC_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                  1'($urandom));
  endtask

  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    board.set_register(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] lo, input logic [15:0] hi,
                           input logic [15:0] spd, input logic dir);
    write_register(REG_POS_MIN, lo);
    write_register(REG_POS_MAX, hi);
    write_register(REG_DEF_SPEED, spd);
    write_register(REG_DOOR_DIR, {15'd0, dir});
  endtask

  task automatic random_commands(input int count);
    int          accepted;
    int          pick;
    logic [1:0]  func;
    logic [3:0]  ch;
    logic [15:0] value;
    logic [15:0] speed;
    accepted = 0;
    while (accepted < count) begin
      pick = $urandom_range(99);
      ch = 4'($urandom_range(CHANNELS - 1));
      if (pick < 58) func = FUNC_TICK;
      else if (pick < 80) func = FUNC_SET;
      else if (pick < 90) func = FUNC_DOOR;
      else if (pick < 95) begin
        func = $urandom_range(1) ? FUNC_SET : FUNC_DOOR;
        ch = 4'($urandom_range(15, CHANNELS));
      end else begin
        func = FUNC_UNUSED;
        ch = 4'($urandom);
      end
      if (func == FUNC_DOOR) value = $urandom_range(1) ? 16'($urandom) : 16'd0;
      else if ($urandom_range(3) == 0) value = 16'($urandom);
      else value = 16'($urandom_range(12000));
      case ($urandom_range(9))
        0, 1: speed = 16'd0;
        2: speed = 16'($urandom);
        default: speed = 16'($urandom_range(3000, 50));
      endcase
      issue_command(func, ch, value, speed, 8'($urandom), 1'($urandom_range(3) == 0));
      if (func != FUNC_UNUSED && int'(ch) < CHANNELS) accepted++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue_command(FUNC_SET, 4'd0, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
    issue_command(FUNC_SET, 4'd7, 16'h0000, 16'h0000, 8'h00, 1'b1);
    issue_command(FUNC_SET, 4'd8, 16'd500, 16'd100, 8'h11, 1'b0);
    issue_command(FUNC_DOOR, 4'd15, 16'd1, 16'd0, 8'h22, 1'b0);
    issue_command(FUNC_UNUSED, 4'd3, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    issue_command(FUNC_DOOR, 4'd1, 16'h8000, 16'hFFFF, 8'hA5, 1'b0);
    issue_command(FUNC_DOOR, 4'd2, 16'h0000, 16'h0000, 8'h5A, 1'b0);
    issue_command(FUNC_SET, 4'd3, 16'h1234, 16'd2000, 8'h01, 1'b0);
    issue_command(FUNC_SET, 4'd5, 16'd9999, 16'h8000, 8'h80, 1'b0);
    repeat (10) tick_random();
    issue_command(FUNC_SET, 4'd0, 16'd0, 16'd3000, 8'h7F, 1'b0);
    repeat (6) tick_random();
    random_commands(76);

    wait_for_quiet();
    configure(16'd1000, 16'd60000, 16'hFFFF, 1'b1);
    random_commands(20);
    hold_request = 1'b1;
    random_commands(56);

    wait_for_quiet();
    configure(16'd50000, 16'd2000, 16'd0, 1'b0);
    random_commands(40);
    wait_for_quiet();
    random_commands(36);

    wait_for_quiet();
    idling_on = 1'b0;
    configure(16'd0, 16'hFFFF, 16'd700, 1'b1);
    random_commands(76);
    idling_on = 1'b1;

    wait_for_quiet();
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    random_commands(76);

    wait_for_quiet();
    configure(16'd0, 16'd0, 16'd300, 1'b1);
    random_commands(76);

    wait_for_quiet();
    if (board.mismatches == 0 && board.results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
